[hw/rtl/cti_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types, codes and defaults of the curve table interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

    localparam int DEF_MAX_CURVES = 16;
    localparam int DEF_MAX_POINTS = 32;

    localparam logic [1:0] FN_POINT  = 2'd0;
    localparam logic [1:0] FN_CURVE  = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_WARN     = 2'd1;
    localparam logic [1:0] STAT_NO_TABLE = 2'd2;

    typedef enum logic [1:0] {CB_ZERO, CB_LAST, CB_J, CB_JM1} t_cb_sel;
    typedef enum logic [1:0] {XZ_FIRST, XZ_LAST, XZ_I, XZ_IM1} t_xz_sel;
    typedef enum logic [1:0] {C_ZERO, C_J, C_JM1} t_c_sel;
    typedef enum logic [1:0] {RES_NONE, RES_ERR, RES_EV, RES_LERP} t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     ld_y0;
        logic     ld_clamp;
        logic     clr_j;
        logic     inc_j;
        logic     fix_j;
        logic     ld_c;
        t_c_sel   c_sel;
        t_cb_sel  cb_sel;
        t_xz_sel  xz_sel;
        logic     ld_xl;
        logic     clr_i;
        logic     inc_i;
        logic     fix_i;
        logic     ev_clamp;
        logic     ev_lerp;
        logic     save_lo;
        logic     save_hi;
        logic     ld_ylo;
        logic     lerp_start;
        logic     lerp_y;
        t_res_sel res_sel;
        logic     push;
    } t_cmd;

    typedef struct packed {
        logic in_query;
        logic have_all;
        logic jstop;
        logic yc_eq_y0;
        logic yc_eq_yn;
        logic x_out;
        logic istop;
        logic lerp_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/cti_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/cti_lerp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_lerp
// Exact linear interpolation unit: one multiply, then a bit-serial divide.
// ----------------------------------------------------------------------------
module cti_lerp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_p,
    input  wire logic signed [31:0] i_pl,
    input  wire logic signed [31:0] i_pu,
    input  wire logic signed [31:0] i_zl,
    input  wire logic signed [31:0] i_zu,
    output logic                    o_done,
    output logic signed [31:0]      o_result
);

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_DIV, L_FIN, L_DONE} t_lstate;

    t_lstate            r_state;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [31:0]        r_mag;
    logic               r_neg;
    logic signed [31:0] r_zl;
    logic [63:0]        r_num;
    logic [31:0]        r_rem;
    logic [5:0]         r_cnt;

    logic signed [32:0] d;
    logic signed [32:0] span;
    logic signed [32:0] dz;
    logic signed [32:0] ndz;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic [32:0]        rem_sub;
    logic [31:0]        q32;

    always_comb begin
        d       = {i_p[31], i_p} - {i_pl[31], i_pl};
        span    = {i_pu[31], i_pu} - {i_pl[31], i_pl};
        dz      = {i_zu[31], i_zu} - {i_zl[31], i_zl};
        ndz     = -dz;
        rem_sh  = {r_rem, r_num[63]};
        rem_sub = rem_sh - {1'b0, r_b};
        qbit    = (rem_sh >= {1'b0, r_b});
        q32     = (r_num > {32'd0, r_mag}) ? r_mag : r_num[31:0];
    end

    assign o_done = (r_state == L_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        if (d <= 33'sd0 || span <= 33'sd0) begin
                            o_result <= i_zl;
                            r_state  <= L_DONE;
                        end else begin
                            r_a     <= d[31:0];
                            r_b     <= span[31:0];
                            r_mag   <= dz[32] ? ndz[31:0] : dz[31:0];
                            r_neg   <= dz[32];
                            r_zl    <= i_zl;
                            r_state <= L_MUL;
                        end
                    end
                end
                L_MUL: begin
                    r_num   <= 64'(r_a) * 64'(r_mag);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem <= qbit ? rem_sub[31:0] : rem_sh[31:0];
                    r_num <= {r_num[62:0], qbit};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    o_result <= r_neg ? (r_zl - $signed(q32)) : (r_zl + $signed(q32));
                    r_state  <= L_DONE;
                end
                L_DONE: begin
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/cti_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_datapath
// Table memories, search counters, operand registers and the result register.
// ----------------------------------------------------------------------------
module cti_datapath #(
    parameter int MAX_CURVES = cti_pkg::DEF_MAX_CURVES,
    parameter int MAX_POINTS = cti_pkg::DEF_MAX_POINTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_func,
    input  wire logic [3:0]         i_curve_index,
    input  wire logic [4:0]         i_point_index,
    input  wire logic signed [31:0] i_table_x,
    input  wire logic signed [31:0] i_table_z,
    input  wire logic signed [31:0] i_curve_y,
    input  wire logic signed [31:0] i_sample_x,
    input  wire logic signed [31:0] i_sample_y,
    input  wire logic [4:0]         i_curve_count,
    input  wire logic [5:0]         i_points_per_curve,
    input  wire cti_pkg::t_cmd      i_cmd,
    output cti_pkg::t_status        o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic signed [31:0]      o_z_out,
    output logic [1:0]              o_status_code
);

    localparam int JW    = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int DEPTH = MAX_CURVES * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);

    logic               r_have_xz;
    logic               r_have_y;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_y0;
    logic signed [31:0] r_yn;
    logic signed [31:0] r_yc;
    logic signed [31:0] r_xl;
    logic signed [31:0] r_zpt;
    logic signed [31:0] r_ev;
    logic signed [31:0] r_zlo;
    logic signed [31:0] r_zhi;
    logic signed [31:0] r_ylo;
    logic signed [31:0] r_res;
    logic               r_warn;
    logic               r_err;
    logic [JW-1:0]      r_j;
    logic [JW-1:0]      r_c;
    logic [PW-1:0]      r_i;

    logic [JW-1:0]      m_last;
    logic [PW-1:0]      n_last;
    logic [JW-1:0]      jf;
    logic [JW-1:0]      cb_raddr;
    logic [PW-1:0]      off;
    logic [AW-1:0]      base;
    logic [AW-1:0]      xz_raddr;
    logic [AW-1:0]      xz_waddr;
    logic               xz_we;
    logic               cb_we;
    logic signed [31:0] cb_rd;
    logic signed [31:0] x_rd;
    logic signed [31:0] z_rd;
    logic signed [31:0] lerp_res;
    logic               lerp_done;

    always_comb begin
        if (i_curve_count == 5'd0) begin
            m_last = '0;
        end else if (32'(i_curve_count) > MAX_CURVES) begin
            m_last = JW'(MAX_CURVES - 1);
        end else begin
            m_last = JW'(i_curve_count - 5'd1);
        end
        if (i_points_per_curve < 6'd2) begin
            n_last = PW'(1);
        end else if (32'(i_points_per_curve) > MAX_POINTS) begin
            n_last = PW'(MAX_POINTS - 1);
        end else begin
            n_last = PW'(i_points_per_curve - 6'd1);
        end
    end

    assign xz_we = i_accept && (i_func == cti_pkg::FN_POINT)
                   && (32'(i_curve_index) < MAX_CURVES) && (32'(i_point_index) < MAX_POINTS);
    assign cb_we = i_accept && (i_func == cti_pkg::FN_CURVE)
                   && (32'(i_curve_index) < MAX_CURVES);
    assign xz_waddr = AW'(32'(i_curve_index) * MAX_POINTS + 32'(i_point_index));

    assign jf = (r_j == '0) ? JW'(1) : r_j;

    always_comb begin
        unique case (i_cmd.cb_sel)
            cti_pkg::CB_ZERO: cb_raddr = '0;
            cti_pkg::CB_LAST: cb_raddr = m_last;
            cti_pkg::CB_J:    cb_raddr = r_j;
            cti_pkg::CB_JM1:  cb_raddr = r_j - JW'(1);
            default:          cb_raddr = '0;
        endcase
        unique case (i_cmd.xz_sel)
            cti_pkg::XZ_FIRST: off = '0;
            cti_pkg::XZ_LAST:  off = n_last;
            cti_pkg::XZ_I:     off = r_i;
            cti_pkg::XZ_IM1:   off = r_i - PW'(1);
            default:           off = '0;
        endcase
        base     = AW'(32'(r_c) * MAX_POINTS);
        xz_raddr = base + AW'(off);
    end

    cti_ram #(.WIDTH(32), .DEPTH(MAX_CURVES)) u_cb_ram (
        .i_clk   (i_clk),
        .i_we    (cb_we),
        .i_waddr (JW'(i_curve_index)),
        .i_wdata (i_curve_y),
        .i_raddr (cb_raddr),
        .o_rdata (cb_rd)
    );

    cti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (xz_we),
        .i_waddr (xz_waddr),
        .i_wdata (i_table_x),
        .i_raddr (xz_raddr),
        .o_rdata (x_rd)
    );

    cti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_z_ram (
        .i_clk   (i_clk),
        .i_we    (xz_we),
        .i_waddr (xz_waddr),
        .i_wdata (i_table_z),
        .i_raddr (xz_raddr),
        .o_rdata (z_rd)
    );

    cti_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.lerp_start),
        .i_p      (i_cmd.lerp_y ? r_y : r_x),
        .i_pl     (i_cmd.lerp_y ? r_ylo : r_xl),
        .i_pu     (i_cmd.lerp_y ? cb_rd : x_rd),
        .i_zl     (i_cmd.lerp_y ? r_zlo : r_zpt),
        .i_zu     (i_cmd.lerp_y ? r_zhi : z_rd),
        .o_done   (lerp_done),
        .o_result (lerp_res)
    );

    always_comb begin
        o_status.in_query  = (i_func == cti_pkg::FN_QUERY);
        o_status.have_all  = r_have_xz && r_have_y;
        o_status.jstop     = (cb_rd >= r_yc) || (r_j == m_last);
        o_status.yc_eq_y0  = (r_yc == r_y0);
        o_status.yc_eq_yn  = (r_yc == r_yn);
        o_status.x_out     = (r_x < r_xl) || (r_x > x_rd);
        o_status.istop     = (x_rd >= r_x) || (r_i == n_last);
        o_status.lerp_done = lerp_done;
        o_status.out_free  = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_xz   <= 1'b0;
            r_have_y    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (xz_we) begin
                r_have_xz <= 1'b1;
            end
            if (cb_we) begin
                r_have_y <= 1'b1;
            end
            if (i_cmd.push) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= i_sample_x;
            r_y    <= i_sample_y;
            r_warn <= 1'b0;
        end
        if (i_cmd.ld_y0) begin
            r_y0 <= cb_rd;
        end
        if (i_cmd.ld_clamp) begin
            r_yn <= cb_rd;
            if (r_y < r_y0) begin
                r_yc   <= r_y0;
                r_warn <= 1'b1;
            end else if (r_y > cb_rd) begin
                r_yc   <= cb_rd;
                r_warn <= 1'b1;
            end else begin
                r_yc <= r_y;
            end
        end
        if (i_cmd.clr_j) begin
            r_j <= '0;
        end else if (i_cmd.inc_j) begin
            r_j <= r_j + JW'(1);
        end else if (i_cmd.fix_j) begin
            r_j <= jf;
        end
        if (i_cmd.ld_c) begin
            unique case (i_cmd.c_sel)
                cti_pkg::C_ZERO: r_c <= '0;
                cti_pkg::C_J:    r_c <= r_j;
                cti_pkg::C_JM1:  r_c <= jf - JW'(1);
                default:         r_c <= '0;
            endcase
        end
        if (i_cmd.ld_xl) begin
            r_xl  <= x_rd;
            r_zpt <= z_rd;
        end
        if (i_cmd.clr_i) begin
            r_i <= '0;
        end else if (i_cmd.inc_i) begin
            r_i <= r_i + PW'(1);
        end else if (i_cmd.fix_i && r_i == '0) begin
            r_i <= PW'(1);
        end
        if (i_cmd.ev_clamp) begin
            r_ev   <= (r_x < r_xl) ? r_zpt : z_rd;
            r_warn <= 1'b1;
        end else if (i_cmd.ev_lerp) begin
            r_ev <= lerp_res;
        end
        if (i_cmd.save_lo) begin
            r_zlo <= r_ev;
        end
        if (i_cmd.save_hi) begin
            r_zhi <= r_ev;
        end
        if (i_cmd.ld_ylo) begin
            r_ylo <= cb_rd;
        end
        unique case (i_cmd.res_sel)
            cti_pkg::RES_NONE: begin
            end
            cti_pkg::RES_ERR: begin
                r_res <= '0;
                r_err <= 1'b1;
            end
            cti_pkg::RES_EV: begin
                r_res <= r_ev;
                r_err <= 1'b0;
            end
            cti_pkg::RES_LERP: begin
                r_res <= lerp_res;
                r_err <= 1'b0;
            end
            default: begin
            end
        endcase
        if (i_cmd.push) begin
            o_z_out       <= r_res;
            o_status_code <= r_err ? cti_pkg::STAT_NO_TABLE
                           : (r_warn ? cti_pkg::STAT_WARN : cti_pkg::STAT_OK);
        end
    end

endmodule
`default_nettype wire

[hw/rtl/cti_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cti_ctrl
// Sequencer for one query: clamp, curve search, point searches, lerps.
// ----------------------------------------------------------------------------
module cti_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire cti_pkg::t_status i_status,
    output logic                  o_ready,
    output cti_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_Y0, S_YN, S_CLAMP, S_JRD, S_JCMP, S_PICK,
        S_EA0, S_EA1, S_ECHK, S_IRD, S_ICMP, S_P0, S_P1, S_P2, S_ELW, S_ERET,
        S_YR0, S_YR1, S_YLS, S_YLW, S_OUT
    } t_state;

    typedef enum logic [1:0] {M_SINGLE, M_LO, M_HI} t_mode;

    t_state r_state;
    t_state n_state;
    t_mode  r_mode;
    t_mode  n_mode;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_status.in_query) begin
                    o_cmd.capture = 1'b1;
                    if (!i_status.have_all) begin
                        o_cmd.res_sel = cti_pkg::RES_ERR;
                        n_state       = S_OUT;
                    end else begin
                        n_state = S_Y0;
                    end
                end
            end
            S_Y0: begin
                o_cmd.cb_sel = cti_pkg::CB_ZERO;
                n_state      = S_YN;
            end
            S_YN: begin
                o_cmd.cb_sel = cti_pkg::CB_LAST;
                o_cmd.ld_y0  = 1'b1;
                n_state      = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.ld_clamp = 1'b1;
                o_cmd.clr_j    = 1'b1;
                n_state        = S_JRD;
            end
            S_JRD: begin
                o_cmd.cb_sel = cti_pkg::CB_J;
                n_state      = S_JCMP;
            end
            S_JCMP: begin
                if (i_status.jstop) begin
                    n_state = S_PICK;
                end else begin
                    o_cmd.inc_j = 1'b1;
                    n_state     = S_JRD;
                end
            end
            S_PICK: begin
                o_cmd.ld_c = 1'b1;
                priority if (i_status.yc_eq_y0) begin
                    o_cmd.c_sel = cti_pkg::C_ZERO;
                    n_mode      = M_SINGLE;
                end else if (i_status.yc_eq_yn) begin
                    o_cmd.c_sel = cti_pkg::C_J;
                    n_mode      = M_SINGLE;
                end else begin
                    o_cmd.c_sel = cti_pkg::C_JM1;
                    o_cmd.fix_j = 1'b1;
                    n_mode      = M_LO;
                end
                n_state = S_EA0;
            end
            S_EA0: begin
                o_cmd.xz_sel = cti_pkg::XZ_FIRST;
                n_state      = S_EA1;
            end
            S_EA1: begin
                o_cmd.ld_xl  = 1'b1;
                o_cmd.xz_sel = cti_pkg::XZ_LAST;
                n_state      = S_ECHK;
            end
            S_ECHK: begin
                if (i_status.x_out) begin
                    o_cmd.ev_clamp = 1'b1;
                    n_state        = S_ERET;
                end else begin
                    o_cmd.clr_i = 1'b1;
                    n_state     = S_IRD;
                end
            end
            S_IRD: begin
                o_cmd.xz_sel = cti_pkg::XZ_I;
                n_state      = S_ICMP;
            end
            S_ICMP: begin
                if (i_status.istop) begin
                    o_cmd.fix_i = 1'b1;
                    n_state     = S_P0;
                end else begin
                    o_cmd.inc_i = 1'b1;
                    n_state     = S_IRD;
                end
            end
            S_P0: begin
                o_cmd.xz_sel = cti_pkg::XZ_IM1;
                n_state      = S_P1;
            end
            S_P1: begin
                o_cmd.ld_xl  = 1'b1;
                o_cmd.xz_sel = cti_pkg::XZ_I;
                n_state      = S_P2;
            end
            S_P2: begin
                o_cmd.lerp_start = 1'b1;
                n_state          = S_ELW;
            end
            S_ELW: begin
                if (i_status.lerp_done) begin
                    o_cmd.ev_lerp = 1'b1;
                    n_state       = S_ERET;
                end
            end
            S_ERET: begin
                unique case (r_mode)
                    M_SINGLE: begin
                        o_cmd.res_sel = cti_pkg::RES_EV;
                        n_state       = S_OUT;
                    end
                    M_LO: begin
                        o_cmd.save_lo = 1'b1;
                        o_cmd.ld_c    = 1'b1;
                        o_cmd.c_sel   = cti_pkg::C_J;
                        n_mode        = M_HI;
                        n_state       = S_EA0;
                    end
                    M_HI: begin
                        o_cmd.save_hi = 1'b1;
                        n_state       = S_YR0;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_YR0: begin
                o_cmd.cb_sel = cti_pkg::CB_JM1;
                n_state      = S_YR1;
            end
            S_YR1: begin
                o_cmd.ld_ylo = 1'b1;
                o_cmd.cb_sel = cti_pkg::CB_J;
                n_state      = S_YLS;
            end
            S_YLS: begin
                o_cmd.lerp_start = 1'b1;
                o_cmd.lerp_y     = 1'b1;
                n_state          = S_YLW;
            end
            S_YLW: begin
                if (i_status.lerp_done) begin
                    o_cmd.res_sel = cti_pkg::RES_LERP;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_SINGLE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/curve_table_2d_interpolator_top.sv]
`default_nettype none
// Load requests are accepted back to back while no query is in progress.
// A query with no table loaded goes straight to its error result; otherwise it runs linear
// searches over the M curves and N points through registered-read memories and at most
// three lerps around a 64-step bit-serial divider, and it may stall on the output.
// One query at a time.
// Synchronous active-low reset clears control state and table-loaded flags.
// ----------------------------------------------------------------------------
// curve_table_2d_interpolator_top
// Curve table bilinear interpolator with stream ports and an APB register port.
// ----------------------------------------------------------------------------
module curve_table_2d_interpolator_top #(
    parameter int MAX_CURVES = cti_pkg::DEF_MAX_CURVES,
    parameter int MAX_POINTS = cti_pkg::DEF_MAX_POINTS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // curve_index[3:0], point_index[8:4], table_x[40:9], table_z[72:41],
    // curve_y[104:73], sample_x[136:105], sample_y[168:137], zero fill
    input  wire logic [175:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // z_out[31:0]
    output logic      [31:0]  m_axis_tdata,
    // status[1:0]
    output logic      [1:0]   m_axis_tuser
);

    logic [4:0]       r_curve_count;
    logic [5:0]       r_points;
    logic             accept;
    cti_pkg::t_cmd    cmd;
    cti_pkg::t_status status;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {26'd0, r_points} : {27'd0, r_curve_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_count <= 5'd1;
            r_points      <= 6'd2;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_points <= pwdata[5:0];
            end else begin
                r_curve_count <= pwdata[4:0];
            end
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    cti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_status (status),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    cti_datapath #(
        .MAX_CURVES (MAX_CURVES),
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_func             (s_axis_tuser),
        .i_curve_index      (s_axis_tdata[3:0]),
        .i_point_index      (s_axis_tdata[8:4]),
        .i_table_x          (s_axis_tdata[40:9]),
        .i_table_z          (s_axis_tdata[72:41]),
        .i_curve_y          (s_axis_tdata[104:73]),
        .i_sample_x         (s_axis_tdata[136:105]),
        .i_sample_y         (s_axis_tdata[168:137]),
        .i_curve_count      (r_curve_count),
        .i_points_per_curve (r_points),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_z_out            (m_axis_tdata),
        .o_status_code      (m_axis_tuser)
    );

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.lerp_done |-> !s_axis_tready)
        else $error("lerp finished while the sequencer was idle");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result pushed over an untaken result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= cti_pkg::STAT_NO_TABLE))
        else $error("invalid result status");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.lerp_start |=> !s_axis_tready)
        else $error("sequencer left the query during a lerp");

endmodule
`default_nettype wire
